// ===== src/scta_pkg.sv =====
// ----------------------------------------------------------------------------
// scta_pkg
// Shared constants, types and lookup tables for the scancode to ascii fifo.
// ----------------------------------------------------------------------------
package scta_pkg;

	// default ring depth (holds one entry fewer than this)
	localparam int DEPTH_DEF = 256;

	// operation codes carried in the input tuser
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result status codes carried in the output tuser
	localparam logic [2:0] ST_STORED     = 3'd0;
	localparam logic [2:0] ST_IGNORED    = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_READ_OK    = 3'd3;
	localparam logic [2:0] ST_READ_EMPTY = 3'd4;

	// set-1 scancodes with special meaning
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
	localparam logic [7:0] SC_RELEASE_BIT  = 8'h80;
	localparam logic [7:0] CASE_BIT        = 8'h20;

	// number of codes covered by the layout tables
	localparam logic [7:0] TABLE_LEN = 8'd59;

	// ring access request from the control stage
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] data;
	} ring_req_t;

	// ring occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

	// us layout, no shift
	function automatic logic [7:0] plain_char(input logic [5:0] code);
		logic [7:0] ch;
		case (code)
			6'h01: ch = 8'h1B;
			6'h02: ch = 8'h31;
			6'h03: ch = 8'h32;
			6'h04: ch = 8'h33;
			6'h05: ch = 8'h34;
			6'h06: ch = 8'h35;
			6'h07: ch = 8'h36;
			6'h08: ch = 8'h37;
			6'h09: ch = 8'h38;
			6'h0A: ch = 8'h39;
			6'h0B: ch = 8'h30;
			6'h0C: ch = 8'h2D;
			6'h0D: ch = 8'h3D;
			6'h0E: ch = 8'h08;
			6'h0F: ch = 8'h09;
			6'h10: ch = 8'h71;
			6'h11: ch = 8'h77;
			6'h12: ch = 8'h65;
			6'h13: ch = 8'h72;
			6'h14: ch = 8'h74;
			6'h15: ch = 8'h79;
			6'h16: ch = 8'h75;
			6'h17: ch = 8'h69;
			6'h18: ch = 8'h6F;
			6'h19: ch = 8'h70;
			6'h1A: ch = 8'h5B;
			6'h1B: ch = 8'h5D;
			6'h1C: ch = 8'h0A;
			6'h1E: ch = 8'h61;
			6'h1F: ch = 8'h73;
			6'h20: ch = 8'h64;
			6'h21: ch = 8'h66;
			6'h22: ch = 8'h67;
			6'h23: ch = 8'h68;
			6'h24: ch = 8'h6A;
			6'h25: ch = 8'h6B;
			6'h26: ch = 8'h6C;
			6'h27: ch = 8'h3B;
			6'h28: ch = 8'h27;
			6'h29: ch = 8'h60;
			6'h2B: ch = 8'h5C;
			6'h2C: ch = 8'h7A;
			6'h2D: ch = 8'h78;
			6'h2E: ch = 8'h63;
			6'h2F: ch = 8'h76;
			6'h30: ch = 8'h62;
			6'h31: ch = 8'h6E;
			6'h32: ch = 8'h6D;
			6'h33: ch = 8'h2C;
			6'h34: ch = 8'h2E;
			6'h35: ch = 8'h2F;
			6'h37: ch = 8'h2A;
			6'h39: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// us layout, shift held
	function automatic logic [7:0] shift_char(input logic [5:0] code);
		logic [7:0] ch;
		case (code)
			6'h01: ch = 8'h1B;
			6'h02: ch = 8'h21;
			6'h03: ch = 8'h40;
			6'h04: ch = 8'h23;
			6'h05: ch = 8'h24;
			6'h06: ch = 8'h25;
			6'h07: ch = 8'h5E;
			6'h08: ch = 8'h26;
			6'h09: ch = 8'h2A;
			6'h0A: ch = 8'h28;
			6'h0B: ch = 8'h29;
			6'h0C: ch = 8'h5F;
			6'h0D: ch = 8'h2B;
			6'h0E: ch = 8'h08;
			6'h0F: ch = 8'h09;
			6'h10: ch = 8'h51;
			6'h11: ch = 8'h57;
			6'h12: ch = 8'h45;
			6'h13: ch = 8'h52;
			6'h14: ch = 8'h54;
			6'h15: ch = 8'h59;
			6'h16: ch = 8'h55;
			6'h17: ch = 8'h49;
			6'h18: ch = 8'h4F;
			6'h19: ch = 8'h50;
			6'h1A: ch = 8'h7B;
			6'h1B: ch = 8'h7D;
			6'h1C: ch = 8'h0A;
			6'h1E: ch = 8'h41;
			6'h1F: ch = 8'h53;
			6'h20: ch = 8'h44;
			6'h21: ch = 8'h46;
			6'h22: ch = 8'h47;
			6'h23: ch = 8'h48;
			6'h24: ch = 8'h4A;
			6'h25: ch = 8'h4B;
			6'h26: ch = 8'h4C;
			6'h27: ch = 8'h3A;
			6'h28: ch = 8'h22;
			6'h29: ch = 8'h7E;
			6'h2B: ch = 8'h7C;
			6'h2C: ch = 8'h5A;
			6'h2D: ch = 8'h58;
			6'h2E: ch = 8'h43;
			6'h2F: ch = 8'h56;
			6'h30: ch = 8'h42;
			6'h31: ch = 8'h4E;
			6'h32: ch = 8'h4D;
			6'h33: ch = 8'h3C;
			6'h34: ch = 8'h3E;
			6'h35: ch = 8'h3F;
			6'h37: ch = 8'h2A;
			6'h39: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== src/scta_ram.sv =====
// ----------------------------------------------------------------------------
// scta_ram
// Generic simple dual-port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module scta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds its value between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/scta_ring.sv =====
// ----------------------------------------------------------------------------
// scta_ring
// Character ring: write and read pointers around the ring memory.
// ----------------------------------------------------------------------------
module scta_ring #(
	parameter int DEPTH = scta_pkg::DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  scta_pkg::ring_req_t    req,
	output scta_pkg::ring_stat_t   stat,
	output logic [7:0]             rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] rd_next;

	// pointer wrap for any depth
	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	// occupancy, one slot kept free
	assign stat.empty = (wr_ptr_q == rd_ptr_q);
	assign stat.full  = (wr_next == rd_ptr_q);

	// pointer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (req.push) begin
				wr_ptr_q <= wr_next;
			end
			if (req.pop) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	scta_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (req.push),
		.wr_addr (wr_ptr_q),
		.wr_data (req.data),
		.rd_en   (req.pop),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

endmodule

// ===== src/scta_xlate.sv =====
// ----------------------------------------------------------------------------
// scta_xlate
// Set-1 scancode translation with shift and caps lock tracking.
// ----------------------------------------------------------------------------
module scta_xlate (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] code,
	output logic [7:0] ch
);

	logic shift_q;
	logic caps_q;
	logic is_shift_make;
	logic is_shift_break;
	logic is_caps;
	logic in_table;
	logic is_letter;
	logic [7:0] raw_ch;

	// modifier decode
	assign is_shift_make  = (code == scta_pkg::SC_LSHIFT_MAKE) ||
	                        (code == scta_pkg::SC_RSHIFT_MAKE);
	assign is_shift_break = (code == scta_pkg::SC_LSHIFT_BREAK) ||
	                        (code == scta_pkg::SC_RSHIFT_BREAK);
	assign is_caps        = (code == scta_pkg::SC_CAPS_MAKE);
	assign in_table       = ((code & scta_pkg::SC_RELEASE_BIT) == 8'h00) &&
	                        (code < scta_pkg::TABLE_LEN);

	// layout lookup and caps lock case flip on letters only
	always_comb begin
		raw_ch = shift_q ? scta_pkg::shift_char(code[5:0])
		                 : scta_pkg::plain_char(code[5:0]);
		is_letter = ((raw_ch >= 8'h61) && (raw_ch <= 8'h7A)) ||
		            ((raw_ch >= 8'h41) && (raw_ch <= 8'h5A));
		if (is_shift_make || is_shift_break || is_caps || !in_table) begin
			ch = 8'h00;
		end else if (caps_q && is_letter) begin
			ch = raw_ch ^ scta_pkg::CASE_BIT;
		end else begin
			ch = raw_ch;
		end
	end

	// modifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (en) begin
			if (is_shift_make) begin
				shift_q <= 1'b1;
			end else if (is_shift_break) begin
				shift_q <= 1'b0;
			end
			if (is_caps) begin
				caps_q <= !caps_q;
			end
		end
	end

endmodule

// ===== src/scancode_to_ascii_fifo_top.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top
// Set-1 keyboard scancode to ascii translator feeding a character ring.
//
// Input stream: tuser is the operation (0 scancode word, 1 read request),
// tdata is the raw scancode byte. Output stream: one word per input word,
// tuser is the status, tdata the character popped on a good read, else 0.
// From input accept to output valid a word passes through an input
// register, then the translation, ring decision and ring memory access,
// then the result register together with the memory's registered read.
// Throughput is one word per cycle unless the receiver stalls; the ring
// memory's single read and write ports are each used at most once per word.
// The ring holds DEPTH-1 characters; a character arriving on a full ring is
// dropped and reported, a read on an empty ring reports empty.
// Reset clears the pipeline, the shift and caps lock flags and the ring
// pointers; the ring memory itself is not cleared.
// When the receiver stalls, the result word holds and one more word waits
// in the input register; s_axis_tready then drops until the output moves.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_top #(
	parameter int DEPTH = scta_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] scancode
	input  logic       s_axis_tuser,  // [0] operation
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] character
	output logic [2:0] m_axis_tuser   // [2:0] status
);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] code_s1;
	logic       valid_s2;
	logic [2:0] status_s2;

	logic                 advance;
	logic [7:0]           ch;
	logic [2:0]           status;
	logic [7:0]           rd_data;
	scta_pkg::ring_req_t  ring_req;
	scta_pkg::ring_stat_t ring_stat;

	// stage handshake
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	scta_xlate u_xlate (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance && (op_s1 == scta_pkg::OP_SCAN)),
		.code   (code_s1),
		.ch     (ch)
	);

	// status decision and ring request
	always_comb begin
		if (op_s1 == scta_pkg::OP_READ) begin
			status = ring_stat.empty ? scta_pkg::ST_READ_EMPTY : scta_pkg::ST_READ_OK;
		end else if (ch == 8'h00) begin
			status = scta_pkg::ST_IGNORED;
		end else if (ring_stat.full) begin
			status = scta_pkg::ST_FULL;
		end else begin
			status = scta_pkg::ST_STORED;
		end
		ring_req.push = advance && (status == scta_pkg::ST_STORED);
		ring_req.pop  = advance && (status == scta_pkg::ST_READ_OK);
		ring_req.data = ch;
	end

	scta_ring #(
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.stat    (ring_stat),
		.rd_data (rd_data)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (!valid_s2 || m_axis_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			code_s1 <= s_axis_tdata;
		end
		if (advance) begin
			status_s2 <= status;
		end
	end

	// result word
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = (status_s2 == scta_pkg::ST_READ_OK) ? rd_data : 8'h00;

endmodule

// ===== src/scta_chk.sv =====
// ----------------------------------------------------------------------------
// scta_chk
// Port-level checks for the scancode to ascii fifo, bound to the top level.
// ----------------------------------------------------------------------------
module scta_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result word changed");

	// status is one of the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == scta_pkg::ST_STORED) ||
			(m_axis_tuser == scta_pkg::ST_IGNORED) ||
			(m_axis_tuser == scta_pkg::ST_FULL) ||
			(m_axis_tuser == scta_pkg::ST_READ_OK) ||
			(m_axis_tuser == scta_pkg::ST_READ_EMPTY))
		else $error("undefined status code");

	// only a good read carries a character
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != scta_pkg::ST_READ_OK) |->
			m_axis_tdata == 8'h00)
		else $error("character on a non-read result");

	// input back-pressure only while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

endmodule

bind scancode_to_ascii_fifo_top scta_chk u_chk (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scancode to ascii fifo. Scancode and read words
// go in through a stream driver with random gaps, results come back through a
// monitor with random stalls. Every accepted input word updates a local copy
// of the shift, caps lock and ring state, and the predicted result is checked
// field by field against the next result word that comes out.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH  = scta_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int KEY_TARGET  = 1050;

	typedef struct {
		logic       op;
		logic [7:0] code;
	} key_word_t;

	typedef struct {
		logic [2:0] status;
		logic [7:0] character;
	} key_result_t;

	// us layout, plain and shifted, codes 0x00..0x3a
	logic [7:0] plain_map [0:58] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00
	};
	logic [7:0] shifted_map [0:58] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] scancode
	logic       s_axis_tuser  = 1'b0;   // [0] operation
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] character
	logic [2:0] m_axis_tuser;           // [2:0] status

	// local copy of the keyboard state and character ring
	logic       shift_on  = 1'b0;
	logic       caps_on   = 1'b0;
	logic [7:0] char_copy [RING_DEPTH];
	int         wr_pos    = 0;
	int         rd_pos    = 0;

	key_word_t   pending_keys [$];
	key_result_t expected_replies [$];
	int          mismatch_cnt = 0;
	int          key_count    = 0;
	int          cycle_cnt    = 0;

	int          send_idle    = 0;
	int          send_burst   = 0;
	logic        send_quiet   = 1'b0;
	int          recv_stall   = 0;
	int          recv_period  = 0;
	logic        recv_quiet   = 1'b0;
	key_word_t   next_key;
	key_result_t got_reply;
	key_result_t want_reply;

	scancode_to_ascii_fifo_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// next state of the keyboard and ring for one accepted word
	function automatic key_result_t predict_key_result(input logic op, input logic [7:0] code);
		key_result_t r;
		logic [7:0]  ch;
		r.status    = scta_pkg::ST_IGNORED;
		r.character = 8'h00;
		ch          = 8'h00;
		if (op == scta_pkg::OP_READ) begin
			if (rd_pos == wr_pos) begin
				r.status = scta_pkg::ST_READ_EMPTY;
			end else begin
				r.character = char_copy[rd_pos];
				rd_pos      = (rd_pos + 1) % RING_DEPTH;
				r.status    = scta_pkg::ST_READ_OK;
			end
		end else begin
			if (code == scta_pkg::SC_LSHIFT_MAKE || code == scta_pkg::SC_RSHIFT_MAKE) begin
				shift_on = 1'b1;
			end else if (code == scta_pkg::SC_LSHIFT_BREAK ||
			             code == scta_pkg::SC_RSHIFT_BREAK) begin
				shift_on = 1'b0;
			end else if (code == scta_pkg::SC_CAPS_MAKE) begin
				caps_on = ~caps_on;
			end else if ((code & scta_pkg::SC_RELEASE_BIT) == 8'h00 &&
			             code < scta_pkg::TABLE_LEN) begin
				ch = shift_on ? shifted_map[code] : plain_map[code];
				// caps lock only touches letters
				if (caps_on && ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)))
					ch = ch ^ scta_pkg::CASE_BIT;
			end
			if (ch != 8'h00) begin
				if ((wr_pos + 1) % RING_DEPTH == rd_pos) begin
					r.status = scta_pkg::ST_FULL;
				end else begin
					char_copy[wr_pos] = ch;
					wr_pos            = (wr_pos + 1) % RING_DEPTH;
					r.status          = scta_pkg::ST_STORED;
				end
			end
		end
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random make code that maps to a character
	function automatic logic [7:0] pick_printable();
		logic [7:0] code;
		code = 8'h00;
		while (plain_map[code] == 8'h00)
			code = 8'($urandom_range(1, 8'h39));
		return code;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("%0t ns mismatch: %s got %0h want %0h", $realtime, what, got_v, want_v);
		mismatch_cnt++;
	endtask

	// queue one input word
	task automatic add_key(input logic op, input logic [7:0] code);
		key_word_t k;
		k.op   = op;
		k.code = code;
		pending_keys.push_back(k);
		key_count++;
	endtask

	// input word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tuser  <= scta_pkg::OP_SCAN;
			send_idle     <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_replies.push_back(predict_key_result(s_axis_tuser, s_axis_tdata));
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the word until taken
			end else if (send_idle != 0) begin
				s_axis_tvalid <= 1'b0;
				send_idle     <= send_idle - 1;
			end else if (pending_keys.size() != 0) begin
				next_key = pending_keys.pop_front();
				if (send_burst == 0) begin
					send_burst = $urandom_range(20, 120);
					send_quiet = ($urandom_range(0, 3) == 0);
				end
				send_burst    = send_burst - 1;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= next_key.code;
				s_axis_tuser  <= next_key.op;
				send_idle     <= send_quiet ? 0 : pick_idle();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result word monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_reply.status    = m_axis_tuser;
				got_reply.character = m_axis_tdata;
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected result word",
						int'({got_reply.status, got_reply.character}), 0);
				end else begin
					want_reply = expected_replies.pop_front();
					if (got_reply.status !== want_reply.status)
						report_mismatch("status", int'(got_reply.status),
							int'(want_reply.status));
					if (got_reply.character !== want_reply.character)
						report_mismatch("character", int'(got_reply.character),
							int'(want_reply.character));
				end
			end
			if (recv_period == 0) begin
				recv_period = $urandom_range(50, 300);
				recv_quiet  = ($urandom_range(0, 2) == 0);
			end
			recv_period = recv_period - 1;
			if (recv_stall != 0) begin
				m_axis_tready <= 1'b0;
				recv_stall    <= recv_stall - 1;
			end else begin
				m_axis_tready <= 1'b1;
				if (!recv_quiet && $urandom_range(0, 3) == 0)
					recv_stall <= pick_idle();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// stimulus and end of test
	initial begin
		int n;
		int kind;
		logic [7:0] code_v;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty read, table edges, shift and caps combinations
		add_key(scta_pkg::OP_READ, 8'hFF);
		add_key(scta_pkg::OP_SCAN, 8'h00);
		add_key(scta_pkg::OP_SCAN, 8'h01);
		add_key(scta_pkg::OP_SCAN, 8'h10);
		add_key(scta_pkg::OP_SCAN, scta_pkg::SC_CAPS_MAKE);
		add_key(scta_pkg::OP_SCAN, 8'h10);
		add_key(scta_pkg::OP_SCAN, 8'h02);
		add_key(scta_pkg::OP_SCAN, scta_pkg::SC_LSHIFT_MAKE);
		add_key(scta_pkg::OP_SCAN, 8'h10);
		add_key(scta_pkg::OP_SCAN, 8'h02);
		add_key(scta_pkg::OP_SCAN, scta_pkg::SC_LSHIFT_BREAK);
		add_key(scta_pkg::OP_SCAN, scta_pkg::SC_RSHIFT_MAKE);
		add_key(scta_pkg::OP_SCAN, 8'h35);
		add_key(scta_pkg::OP_SCAN, scta_pkg::SC_RSHIFT_BREAK);
		add_key(scta_pkg::OP_SCAN, scta_pkg::SC_CAPS_MAKE);
		add_key(scta_pkg::OP_SCAN, 8'h3B);
		add_key(scta_pkg::OP_SCAN, 8'hFF);
		add_key(scta_pkg::OP_SCAN, 8'h39);
		for (int i = 0; i < 9; i++)
			add_key(scta_pkg::OP_READ, (i % 2 == 0) ? 8'h00 : 8'hFF);

		// flood the ring past full
		for (int i = 0; i < 270; i++)
			add_key(scta_pkg::OP_SCAN, pick_printable());

		// let everything drain before the read burst
		while (pending_keys.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(negedge clk);

		for (int i = 0; i < 262; i++)
			add_key(scta_pkg::OP_READ, 8'($urandom_range(0, 255)));

		// random typing sequences with some noise
		while (key_count < KEY_TARGET) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					n = $urandom_range(1, 8);
					for (int i = 0; i < n; i++) begin
						code_v = pick_printable();
						add_key(scta_pkg::OP_SCAN, code_v);
						if ($urandom_range(0, 1) == 1)
							add_key(scta_pkg::OP_SCAN, code_v | scta_pkg::SC_RELEASE_BIT);
					end
				end
				4: begin
					add_key(scta_pkg::OP_SCAN, $urandom_range(0, 1) ?
						scta_pkg::SC_LSHIFT_MAKE : scta_pkg::SC_RSHIFT_MAKE);
					n = $urandom_range(1, 5);
					for (int i = 0; i < n; i++)
						add_key(scta_pkg::OP_SCAN, pick_printable());
					add_key(scta_pkg::OP_SCAN, $urandom_range(0, 1) ?
						scta_pkg::SC_LSHIFT_BREAK : scta_pkg::SC_RSHIFT_BREAK);
				end
				5: begin
					add_key(scta_pkg::OP_SCAN, scta_pkg::SC_CAPS_MAKE);
					if ($urandom_range(0, 1) == 1)
						add_key(scta_pkg::OP_SCAN,
							scta_pkg::SC_CAPS_MAKE | scta_pkg::SC_RELEASE_BIT);
				end
				6, 7: begin
					n = $urandom_range(1, 8);
					for (int i = 0; i < n; i++)
						add_key(scta_pkg::OP_READ, 8'($urandom_range(0, 255)));
				end
				8: begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						add_key(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end
				default: begin
					add_key(scta_pkg::OP_SCAN, 8'($urandom_range(8'h3B, 8'h7F)));
				end
			endcase
		end

		// wait for the last results, then let the clock idle before reporting
		while (pending_keys.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/scta_pkg.sv
src/scta_ram.sv
src/scta_ring.sv
src/scta_xlate.sv
src/scancode_to_ascii_fifo_top.sv
src/scta_chk.sv
bench/tb_top.sv
